>>> src/vec3_normalize_macros.svh
// ----------------------------------------------------------------------------
// vec3_normalize_macros: assertion macros for the vector normalizer
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VEC3_NORMALIZE_MACROS_SVH
`define VEC3_NORMALIZE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vec3_normalize check failed");
`define VN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vec3_normalize check failed");
`else
`define VN_ASSERT_SAME(label, ante, cons)
`define VN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants of the vector normalizer
// Word layouts, derived widths and the sideband carried through the root.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int IN_BITS       = 16;
  localparam int OUT_FRAC_BITS = 15;
  localparam int LANES         = 3;

  localparam int MAG_W  = IN_BITS + 1;
  localparam int SQ_W   = 2 * IN_BITS - 1;
  localparam int SUM_W  = 2 * IN_BITS;
  localparam int RAD_W  = SUM_W + 2 * OUT_FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int DREM_W = ROOT_W + 1;
  localparam int Q_W    = OUT_FRAC_BITS + 1;
  localparam int OUT_W  = OUT_FRAC_BITS + 1;
  localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'((1 << OUT_FRAC_BITS) - 1);

  typedef struct packed {
    logic signed [IN_BITS-1:0] comp_x;
    logic signed [IN_BITS-1:0] comp_y;
    logic signed [IN_BITS-1:0] comp_z;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] unit_x;
    logic signed [OUT_W-1:0] unit_y;
    logic signed [OUT_W-1:0] unit_z;
    logic                    was_zero;
  } out_word_t;

  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [LANES-1:0]            neg;
    logic                        zero;
  } side_t;

  typedef logic [LANES-1:0][Q_W-1:0] quo_vec_t;

endpackage

>>> src/vn_sqrt.sv
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined integer square root
// One result bit per stage, digit by digit, of the sum shifted up by 2F bits.
// ----------------------------------------------------------------------------
module vn_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [vn_pkg::SUM_W-1:0]  in_sum,
  input  vn_pkg::side_t             in_side,
  output logic                      out_vld,
  output logic [vn_pkg::ROOT_W-1:0] out_root,
  output vn_pkg::side_t             out_side
);
  import vn_pkg::*;

  logic [ROOT_W-1:0] vld_r;
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];

  genvar k;
  for (k = 0; k < ROOT_W; k++) begin : g_stage
    logic              src_vld;
    logic [RAD_W-1:0]  src_rad;
    logic [REM_W-1:0]  src_rem;
    logic [ROOT_W-1:0] src_root;
    side_t             src_side;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_rad  = {in_sum, (2 * OUT_FRAC_BITS)'(0)};
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld_r[k-1];
      assign src_rad  = rad_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_side = side_r[k-1];
    end

    assign rem_sh = {src_rem[REM_W-3:0], src_rad[RAD_W-1:RAD_W-2]};
    assign trial  = REM_W'({src_root, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {src_rad[RAD_W-3:0], 2'b00};
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {src_root[ROOT_W-2:0], ge};
        side_r[k] <= src_side;
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

>>> src/vn_div_lane.sv
// ----------------------------------------------------------------------------
// vn_div_lane: pipelined restoring divider for one component
// Computes floor(mag * 2^2F / root), one quotient bit per stage.
// ----------------------------------------------------------------------------
module vn_div_lane (
  input  logic                      clk,
  input  logic                      en,
  input  logic [vn_pkg::MAG_W-1:0]  in_mag,
  input  logic [vn_pkg::ROOT_W-1:0] in_root,
  output logic [vn_pkg::Q_W-1:0]    out_quo
);
  import vn_pkg::*;

  logic [DREM_W-1:0] rem_r  [Q_W];
  logic [ROOT_W-1:0] den_r  [Q_W];
  logic [Q_W-1:0]    quo_r  [Q_W];

  // The quotient never exceeds 2^F, so the dividend's top part already sits
  // below the divisor and only zero bits are shifted in afterward.
  logic [DREM_W-1:0] init_rem;
  assign init_rem = DREM_W'({in_mag, (OUT_FRAC_BITS - 1)'(0)});

  genvar k;
  for (k = 0; k < Q_W; k++) begin : g_stage
    logic [DREM_W-1:0] src_rem;
    logic [ROOT_W-1:0] src_den;
    logic [Q_W-1:0]    src_quo;
    logic [DREM_W-1:0] rem_sh;
    logic [DREM_W-1:0] den_ext;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_rem = init_rem;
      assign src_den = in_root;
      assign src_quo = '0;
    end else begin : g_next
      assign src_rem = rem_r[k-1];
      assign src_den = den_r[k-1];
      assign src_quo = quo_r[k-1];
    end

    assign rem_sh  = {src_rem[DREM_W-2:0], 1'b0};
    assign den_ext = DREM_W'(src_den);
    assign ge      = (rem_sh >= den_ext);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rem_sh - den_ext) : rem_sh;
        den_r[k] <= src_den;
        quo_r[k] <= {src_quo[Q_W-2:0], ge};
      end
    end
  end

  assign out_quo = quo_r[Q_W-1];

endmodule

>>> src/vn_merge.sv
// ----------------------------------------------------------------------------
// vn_merge: result assembly and output buffering
// Clamps and signs the lane quotients, then holds words in an output
// register backed by one skid entry.
// ----------------------------------------------------------------------------
module vn_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tail_vld,
  input  vn_pkg::quo_vec_t           tail_quo,
  input  logic [vn_pkg::LANES-1:0]   tail_neg,
  input  logic                       tail_zero,
  output logic                       skid_full,
  output logic                       out_valid,
  input  logic                       out_stall,
  output vn_pkg::out_word_t          out_word
);
  import vn_pkg::*;

  logic [LANES-1:0][OUT_W-1:0] unit;
  out_word_t word;
  out_word_t out_r, skid_r;
  logic      out_vld_r, skid_full_r;
  logic      tail_fire, out_free;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [OUT_W-1:0] mag_c;
    assign mag_c   = (tail_quo[i] > Q_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(tail_quo[i]);
    assign unit[i] = tail_zero ? '0 : (tail_neg[i] ? (OUT_W'(0) - mag_c) : mag_c);
  end

  always_comb begin
    word.unit_x   = unit[0];
    word.unit_y   = unit[1];
    word.unit_z   = unit[2];
    word.was_zero = tail_zero;
  end

  assign tail_fire = tail_vld && !skid_full_r;
  assign out_free  = !out_vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_free) begin
      if (skid_full_r) begin
        out_vld_r   <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_vld_r <= tail_fire;
      end
    end else if (tail_fire) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_full_r ? skid_r : word;
    end else if (tail_fire) begin
      skid_r <= word;
    end
  end

  assign skid_full = skid_full_r;
  assign out_valid = out_vld_r;
  assign out_word  = out_r;

endmodule

>>> src/vec3_normalize.sv
// ----------------------------------------------------------------------------
// vec3_normalize: scales a 3D Q8.8 vector to unit length in Q1.15
// Throughput: one vector per cycle while in_stall is low; the square root and
// divider lanes are fully pipelined, one result bit per stage.
// A downstream stall freezes the pipeline once the skid entry fills.
// Synchronous active-low reset clears all valid bits; no data is flushed.
// ----------------------------------------------------------------------------
`include "vec3_normalize_macros.svh"

module vec3_normalize (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vn_pkg::in_word_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output vn_pkg::out_word_t out_word
);
  import vn_pkg::*;

  logic en;
  logic skid_full;

  // Stage A: magnitudes and signs.
  logic [LANES-1:0][MAG_W-1:0] mag_a_r;
  logic [LANES-1:0]            neg_a_r;
  logic                        vld_a_r;
  logic [LANES-1:0][IN_BITS-1:0] comp;

  // Stage B: squares.
  logic [LANES-1:0][SQ_W-1:0]  sq_b_r;
  side_t                       side_b_r;
  logic                        vld_b_r;

  // Stage C: sum of squares.
  logic [SUM_W-1:0]            sum_c_r;
  side_t                       side_c_r;
  logic                        vld_c_r;

  logic                        root_vld;
  logic [ROOT_W-1:0]           root;
  side_t                       root_side;

  quo_vec_t                    quo;
  logic [Q_W-1:0]              dvld_r;
  logic [LANES-1:0]            dneg_r  [Q_W];
  logic [Q_W-1:0]              dzero_r;

  assign en       = !skid_full;
  assign in_stall = skid_full;

  assign comp[0] = in_word.comp_x;
  assign comp[1] = in_word.comp_y;
  assign comp[2] = in_word.comp_z;

  for (genvar i = 0; i < LANES; i++) begin : g_front
    logic [MAG_W-1:0]   ext;
    logic [2*MAG_W-1:0] prod;
    assign ext  = {comp[i][IN_BITS-1], comp[i]};
    assign prod = mag_a_r[i] * mag_a_r[i];

    always_ff @(posedge clk) begin
      if (en) begin
        mag_a_r[i] <= comp[i][IN_BITS-1] ? (~ext + MAG_W'(1)) : ext;
        neg_a_r[i] <= comp[i][IN_BITS-1];
        sq_b_r[i]  <= prod[SQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_b_r.mag  <= mag_a_r;
      side_b_r.neg  <= neg_a_r;
      side_b_r.zero <= (mag_a_r == '0);
      sum_c_r       <= SUM_W'(sq_b_r[0]) + SUM_W'(sq_b_r[1]) + SUM_W'(sq_b_r[2]);
      side_c_r      <= side_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  vn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_c_r),
    .in_sum   (sum_c_r),
    .in_side  (side_c_r),
    .out_vld  (root_vld),
    .out_root (root),
    .out_side (root_side)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vn_div_lane u_div (
      .clk     (clk),
      .en      (en),
      .in_mag  (root_side.mag[i]),
      .in_root (root),
      .out_quo (quo[i])
    );
  end

  // Signs and the zero flag ride alongside the divider lanes.
  for (genvar k = 0; k < Q_W; k++) begin : g_dside
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[k] <= 1'b0;
      end else if (en) begin
        dvld_r[k] <= (k == 0) ? root_vld : dvld_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dneg_r[k]  <= (k == 0) ? root_side.neg  : dneg_r[(k == 0) ? 0 : k-1];
        dzero_r[k] <= (k == 0) ? root_side.zero : dzero_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  vn_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .tail_vld  (dvld_r[Q_W-1]),
    .tail_quo  (quo),
    .tail_neg  (dneg_r[Q_W-1]),
    .tail_zero (dzero_r[Q_W-1]),
    .skid_full (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  `VN_ASSERT_SAME(a_zero_word, out_valid && out_word.was_zero, out_word.unit_x == '0 && out_word.unit_y == '0 && out_word.unit_z == '0)
  `VN_ASSERT_SAME(a_skid_needs_out, skid_full, out_valid)
  `VN_ASSERT_SAME(a_skid_fill_on_stall, $rose(skid_full), $past(out_stall))
  `VN_ASSERT_SAME(a_no_min_code, out_valid, out_word.unit_x != {1'b1, {OUT_FRAC_BITS{1'b0}}})

endmodule

>>> verif/vec3_normalize_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vec3_normalize_test: self-checking bench for the vector normalizer
// Drives directed and random Q8.8 vectors through the valid/stall handshake,
// predicts each unit vector in Q1.15 and compares every result word in order.
// ----------------------------------------------------------------------------
module vec3_normalize_test;
  import vn_pkg::*;

  class unit_scoreboard;
    out_word_t pending[$];
    int errors;
    int checked;
    int zeros_seen;

    // Digit-by-digit square root of s * 2^30, rounded down.
    function automatic logic [62:0] scaled_root(logic [63:0] s);
      logic [63:0] root;
      logic [63:0] rem;
      logic [63:0] trial;
      root = 0;
      rem = 0;
      for (int i = 31 + OUT_FRAC_BITS; i >= 0; i--) begin
        rem = (rem << 2) | ((i >= OUT_FRAC_BITS) ? ((s >> (2 * (i - OUT_FRAC_BITS))) & 3) : 0);
        trial = (root << 2) | 1;
        if (rem >= trial) begin
          rem = rem - trial;
          root = (root << 1) | 1;
        end else begin
          root = root << 1;
        end
      end
      return root[62:0];
    endfunction

    function automatic out_word_t unit_of(in_word_t v);
      logic [63:0] mag[3];
      logic neg[3];
      logic [63:0] sum;
      logic [63:0] len;
      logic [127:0] q;
      logic [OUT_W-1:0] lane[3];
      out_word_t r;
      mag[0] = v.comp_x[IN_BITS-1] ? -64'(v.comp_x) : 64'(v.comp_x);
      mag[1] = v.comp_y[IN_BITS-1] ? -64'(v.comp_y) : 64'(v.comp_y);
      mag[2] = v.comp_z[IN_BITS-1] ? -64'(v.comp_z) : 64'(v.comp_z);
      neg[0] = v.comp_x[IN_BITS-1];
      neg[1] = v.comp_y[IN_BITS-1];
      neg[2] = v.comp_z[IN_BITS-1];
      sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      r = '0;
      if (sum == 0) begin
        r.was_zero = 1'b1;
        return r;
      end
      len = scaled_root(sum);
      for (int k = 0; k < 3; k++) begin
        q = (128'(mag[k]) << (2 * OUT_FRAC_BITS)) / len;
        if (q > 128'(OUT_MAX)) q = 128'(OUT_MAX);
        lane[k] = neg[k] ? -q[OUT_W-1:0] : q[OUT_W-1:0];
      end
      r.unit_x = lane[0];
      r.unit_y = lane[1];
      r.unit_z = lane[2];
      return r;
    endfunction

    function void note_input(in_word_t v);
      pending.push_back(unit_of(v));
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.was_zero) zeros_seen++;
      if (got.unit_x !== want.unit_x)
        $display("%0t: unit_x expected %0d actual %0d", $time, want.unit_x, got.unit_x);
      if (got.unit_y !== want.unit_y)
        $display("%0t: unit_y expected %0d actual %0d", $time, want.unit_y, got.unit_y);
      if (got.unit_z !== want.unit_z)
        $display("%0t: unit_z expected %0d actual %0d", $time, want.unit_z, got.unit_z);
      if (got.was_zero !== want.was_zero)
        $display("%0t: was_zero expected %b actual %b", $time, want.was_zero, got.was_zero);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  unit_scoreboard board = new();
  int long_hold = 0;
  int sent = 0;
  bit stim_done = 0;

  always #6 clk = ~clk;

  vec3_normalize u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_word);
  end

  // Stall pattern: free-running stretches, random stalls, and one long hold.
  initial begin
    int mode;
    int span;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      for (int i = 0; i < span; i++) begin
        @(posedge clk);
        if (long_hold > 0) begin
          out_stall <= 1'b1;
          long_hold <= long_hold - 1;
        end else if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else if (mode == 2) out_stall <= ($urandom_range(0, 1) == 0);
        else out_stall <= ($urandom_range(0, 9) != 0);
      end
    end
  end

  // Offers one word and holds it until accepted.
  task automatic send_word(in_word_t v);
    in_valid <= 1'b1;
    in_word <= v;
    do @(posedge clk); while (in_stall);
    board.note_input(v);
    sent++;
  endtask

  task automatic pause_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [IN_BITS-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return IN_BITS'($urandom_range(0, 3));
      1: return -IN_BITS'($urandom_range(1, 3));
      2: return 16'h8000;
      3: return 16'h7fff;
      4: return IN_BITS'($urandom_range(0, 511)) - 16'd256;
      default: return IN_BITS'($urandom());
    endcase
  endfunction

  initial begin
    in_word_t v;
    logic [IN_BITS-1:0] edges[6];
    int burst;
    bit drained;
    drained = 1'b0;
    edges = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h0100};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero vector, single axes, extreme and mixed components.
    for (int i = 0; i < 6; i++) begin
      v.comp_x = edges[i];
      v.comp_y = edges[(i + 2) % 6];
      v.comp_z = edges[(i + 4) % 6];
      send_word(v);
      v = '{edges[i], 16'h0000, 16'h0000};
      send_word(v);
      v = '{16'h0000, 16'h0000, edges[i]};
      send_word(v);
    end
    send_word('{16'h8000, 16'h8000, 16'h8000});
    send_word('{16'h7fff, 16'h7fff, 16'h7fff});
    send_word('{16'h0000, 16'h8000, 16'h0000});

    // Long downstream hold while words keep coming, to fill the pipeline.
    long_hold = 150;
    for (int i = 0; i < 120; i++) begin
      v = '{rand_comp(), rand_comp(), rand_comp()};
      send_word(v);
    end

    while (sent < 1830) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) begin
        v = '{rand_comp(), rand_comp(), rand_comp()};
        send_word(v);
      end
      if ($urandom_range(0, 2) == 0) pause_cycles($urandom_range(1, 12));
      if (sent > 900 && !drained) begin
        // Let the pipeline drain completely before continuing.
        drained = 1'b1;
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d vectors, checked %0d unit results, %0d of them zero vectors.",
             sent, board.checked, board.zeros_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/vn_pkg.sv
src/vn_sqrt.sv
src/vn_div_lane.sv
src/vn_merge.sv
src/vec3_normalize.sv
verif/vec3_normalize_test.sv
